@@ rtl/sss_pkg.sv @@
// Shared constants and control types of the sample set statistics block.
package sss_pkg;

    // Block configuration.
    localparam int MAX_COUNT    = 1024;
    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 16;

    // Fixed widths of the result fields.
    localparam int MEAN_W  = 32;
    localparam int VAR_W   = 46;
    localparam int COUNT_W = 11;

    // Accumulator widths.
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_COUNT);
    localparam int MAG_W = SUM_W;
    localparam int SQ_W  = 2 * SAMPLE_WIDTH - 1 + $clog2(MAX_COUNT);

    // Variance arithmetic widths.
    localparam int N2_W   = 2 * COUNT_W;
    localparam int A_W    = COUNT_W + SQ_W;
    localparam int B_W    = 2 * MAG_W;
    localparam int D_W    = (A_W > B_W) ? A_W : B_W;

    // Shared divider: numerator and divisor widths.
    localparam int DIV_W     = D_W + FRAC_BITS + 2;
    localparam int DEN_W     = N2_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Saturation limits of the mean magnitude.
    localparam logic [DIV_W-1:0] MEAN_NEG_LIM = DIV_W'(64'h0000_0000_8000_0000);
    localparam logic [DIV_W-1:0] MEAN_POS_LIM = DIV_W'(64'h0000_0000_7FFF_FFFF);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_en;
        logic mag_en;
        logic sq_en;
        logic sub_en;
        logic div_start;
        logic div_var;
        logic mean_cap;
        logic load_out;
    } sss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic div_busy;
        logic out_free;
    } sss_sts_t;

endpackage

@@ rtl/sss_if.sv @@
// Valid/ready channel interfaces for samples and for results.
interface sss_in_if import sss_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface sss_out_if import sss_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] max_value;
    logic signed [SAMPLE_WIDTH-1:0] min_value;
    logic signed [MEAN_W-1:0]       mean_q16;
    logic        [VAR_W-1:0]        variance_q16;
    logic        [COUNT_W-1:0]      sample_count;
    logic                           overflowed;

    modport source (output valid, output max_value, output min_value, output mean_q16,
                    output variance_q16, output sample_count, output overflowed,
                    input ready);
    modport sink (input valid, input max_value, input min_value, input mean_q16,
                  input variance_q16, input sample_count, input overflowed,
                  output ready);
endinterface

@@ rtl/sss_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module sss_div import sss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [DIV_W-1:0] quotient,
    output logic             busy,
    output logic             done
);

    logic [DEN_W-1:0]     rem_reg,  rem_next;
    logic [DIV_W-1:0]     quo_reg,  quo_next;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       diff;
    logic                 ge;

    // The numerator shifts out at the top while quotient bits shift in below.
    // The divisor is held from the start so that the caller may change it.
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
        diff     = rem_sh - {1'b0, den_reg};
        ge       = (rem_sh >= {1'b0, den_reg});
        rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

@@ rtl/sss_dp.sv @@
// Datapath: accumulators, product registers, shared divider and output register.
module sss_dp import sss_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  sss_cmd_t                       cmd,
    output sss_sts_t                       sts,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] max_value,
    output logic signed [SAMPLE_WIDTH-1:0] min_value,
    output logic signed [MEAN_W-1:0]       mean_q16,
    output logic        [VAR_W-1:0]        variance_q16,
    output logic        [COUNT_W-1:0]      sample_count,
    output logic                           overflowed
);

    // Accumulators.
    logic        [COUNT_W-1:0]      count_reg;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic        [SQ_W-1:0]         sumsq_reg;
    logic                           drop_reg;

    // Products and intermediate results.
    logic                           neg_reg;
    logic        [MAG_W-1:0]        mag_reg;
    logic        [N2_W-1:0]         n2_reg;
    logic        [D_W-1:0]          a_reg;
    logic        [D_W-1:0]          b_reg;
    logic        [D_W-1:0]          d_reg;
    logic signed [MEAN_W-1:0]       mean_reg;

    // Output register.
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_max_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_min_reg;
    logic signed [MEAN_W-1:0]       out_mean_reg;
    logic        [VAR_W-1:0]        out_var_reg;
    logic        [COUNT_W-1:0]      out_count_reg;
    logic                           out_drop_reg;

    logic signed [2*SAMPLE_WIDTH-1:0] sq_full;
    logic        [SQ_W-1:0]           sq_ext;
    logic                             full;
    logic        [SUM_W-1:0]          neg_sum;
    logic        [N2_W-1:0]           n2_next;
    logic        [D_W-1:0]            a_next;
    logic        [D_W-1:0]            b_next;
    logic        [DIV_W-1:0]          mean_num;
    logic        [DIV_W-1:0]          var_num;
    logic        [DIV_W-1:0]          div_num;
    logic        [DEN_W-1:0]          div_den;
    logic        [DIV_W-1:0]          quotient;
    logic        [DIV_W-1:0]          q_sat;
    logic signed [MEAN_W-1:0]         mean_next;
    logic                             div_busy;
    logic                             div_done;

    always_comb
    begin
        sq_full = sample * sample;
        sq_ext  = SQ_W'(sq_full[2*SAMPLE_WIDTH-2:0]);
        full    = (count_reg == COUNT_W'(MAX_COUNT));
        neg_sum = -sum_reg;
        n2_next = count_reg * count_reg;
        a_next  = count_reg * sumsq_reg;
        b_next  = mag_reg * mag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= '0;
            min_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            count_reg <= '0;
            max_reg   <= '0;
            min_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (full)
            begin
                drop_reg <= 1'b1;
            end
            else
            begin
                if (count_reg == '0)
                begin
                    max_reg <= sample;
                    min_reg <= sample;
                end
                else
                begin
                    if (sample > max_reg)
                    begin
                        max_reg <= sample;
                    end
                    if (sample < min_reg)
                    begin
                        min_reg <= sample;
                    end
                end
                sum_reg   <= sum_reg + SUM_W'(sample);
                sumsq_reg <= sumsq_reg + sq_ext;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Post-set arithmetic, one register after each product.
    always_ff @(posedge clk)
    begin
        if (cmd.mag_en)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            mag_reg <= sum_reg[SUM_W-1] ? neg_sum : sum_reg;
            n2_reg  <= n2_next;
            a_reg   <= a_next;
        end
        if (cmd.sq_en)
        begin
            b_reg <= b_next;
        end
        if (cmd.sub_en)
        begin
            d_reg <= (a_reg >= b_reg) ? (a_reg - b_reg) : '0;
        end
        if (cmd.mean_cap)
        begin
            mean_reg <= mean_next;
        end
    end

    // Round to nearest: (2 * x * 2^F + n) / (2 * n).
    always_comb
    begin
        mean_num = DIV_W'({mag_reg, {(FRAC_BITS + 1){1'b0}}}) + DIV_W'(count_reg);
        var_num  = DIV_W'({d_reg, {(FRAC_BITS + 1){1'b0}}}) + DIV_W'(n2_reg);
        if (cmd.div_var)
        begin
            div_num = var_num;
            div_den = DEN_W'({n2_reg, 1'b0});
        end
        else
        begin
            div_num = mean_num;
            div_den = DEN_W'({count_reg, 1'b0});
        end
    end

    sss_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    // Mean saturates to the signed 32-bit range.
    always_comb
    begin
        q_sat = (quotient > MEAN_NEG_LIM) ? MEAN_NEG_LIM : quotient;
        if (neg_reg)
        begin
            mean_next = -MEAN_W'(q_sat);
        end
        else if (q_sat > MEAN_POS_LIM)
        begin
            mean_next = MEAN_W'(MEAN_POS_LIM);
        end
        else
        begin
            mean_next = MEAN_W'(q_sat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_max_reg   <= max_reg;
            out_min_reg   <= min_reg;
            out_mean_reg  <= mean_reg;
            out_var_reg   <= quotient[VAR_W-1:0];
            out_count_reg <= count_reg;
            out_drop_reg  <= drop_reg;
        end
    end

    always_comb
    begin
        sts.div_done = div_done;
        sts.div_busy = div_busy;
        sts.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign max_value    = out_max_reg;
    assign min_value    = out_min_reg;
    assign mean_q16     = out_mean_reg;
    assign variance_q16 = out_var_reg;
    assign sample_count = out_count_reg;
    assign overflowed   = out_drop_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_COUNT))
        else $error("sample count beyond the maximum");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> full)
        else $error("drop flag set while the set is not full");

    a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (out_valid_reg && count_reg == '0 && !drop_reg))
        else $error("accumulators not cleared after a result was loaded");
`endif

endmodule

@@ rtl/sss_ctrl.sv @@
// Controller: sequences accumulation, the post-set arithmetic and the result load.
module sss_ctrl import sss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    output logic     in_ready,
    input  sss_sts_t sts,
    output sss_cmd_t cmd
);

    localparam logic [3:0] ST_ACC       = 4'd0;
    localparam logic [3:0] ST_MAG       = 4'd1;
    localparam logic [3:0] ST_SQ        = 4'd2;
    localparam logic [3:0] ST_SUB       = 4'd3;
    localparam logic [3:0] ST_MEAN_GO   = 4'd4;
    localparam logic [3:0] ST_MEAN_WAIT = 4'd5;
    localparam logic [3:0] ST_VAR_GO    = 4'd6;
    localparam logic [3:0] ST_VAR_WAIT  = 4'd7;
    localparam logic [3:0] ST_LOAD      = 4'd8;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_ACC:
            begin
                in_ready   = 1'b1;
                cmd.acc_en = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                cmd.mag_en = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq_en  = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.sub_en = 1'b1;
                state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.mean_cap = 1'b1;
                    state_next   = ST_VAR_GO;
                end
            end
            ST_VAR_GO:
            begin
                cmd.div_var   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_VAR_WAIT;
            end
            ST_VAR_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an item not yet taken");

    a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc_en && in_last) |=> !in_ready)
        else $error("samples accepted while a set is being finished");
`endif

endmodule

@@ rtl/sample_set_statistics.sv @@
// Top level of the sample set statistics block: min, max, mean and variance of a set.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------------
//  samples  | in        | sample (16, signed), last
//  results  | out       | max_value, min_value, mean_q16, variance_q16, sample_count,
//           |           | overflowed
//
// Samples are taken one per cycle while a set is open. After the sample marked
// last, the block takes no samples while it forms the products and a subtraction
// (states MAG, SQ and SUB), then the shared radix-2 divider produces the mean
// and then the variance at one quotient bit per cycle over its 70-bit numerator.
// The result item sits in an output register; the block reopens for the next
// set as soon as that register is loaded, so a waiting result holds back only
// the following result, not the following samples. Reset is asynchronous and
// active low; it clears the controller, the accumulators and the output valid.
module sample_set_statistics import sss_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    sss_in_if.sink    samples,
    sss_out_if.source results
);

    sss_cmd_t cmd;
    sss_sts_t sts;

    // The controller owns the sequencing; it sees only handshake and status bits.
    sss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_last  (samples.last),
        .in_ready (samples.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds all the arithmetic and the output register.
    sss_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sample       (samples.sample),
        .out_ready    (results.ready),
        .out_valid    (results.valid),
        .max_value    (results.max_value),
        .min_value    (results.min_value),
        .mean_q16     (results.mean_q16),
        .variance_q16 (results.variance_q16),
        .sample_count (results.sample_count),
        .overflowed   (results.overflowed)
    );

endmodule
